// ===== rtl/xsr_pkg.sv =====
// Shared constants, codes and controller/datapath link types of the random source.
package xsr_pkg;

    localparam logic [63:0] GW_INIT0 = 64'h853c49e6748fea9b;
    localparam logic [63:0] GW_INIT1 = 64'hda3e39cb94b95bdb;
    localparam logic [63:0] GW_INIT2 = 64'h5b5ad4ceb667f385;
    localparam logic [63:0] GW_INIT3 = 64'h9266677dc26f26e8;

    localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

    localparam int ROT_OUT  = 7;
    localparam int ROT_W3   = 45;
    localparam int SHIFT_W1 = 17;

    // exponent of a mantissa whose leading one already sits at bit 52
    localparam logic [10:0] EXP_START = 11'd1022;

    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ACT_SEED = 2'd0,
        ACT_INT  = 2'd1,
        ACT_REAL = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SM_ADD,
        OP_SM_XS30,
        OP_SM_XS27,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_SM_STORE,
        OP_ADVANCE,
        OP_SCRAMBLE,
        OP_DIV_STEP,
        OP_REAL_INIT,
        OP_NORM_STEP,
        OP_FIN_EMPTY,
        OP_FIN_INT,
        OP_FIN_REAL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       mul_sel;   // 0: first mixing constant, 1: second
        logic [1:0] word_idx;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full_span;
        logic mant_top;
        logic mant_zero;
    } status_t;

endpackage

// ===== rtl/xsr_if.sv =====
// Request and result channel interfaces of the random source.
interface xsr_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [63:0]        seed_value;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;

    modport source (output valid, action, seed_value, low_bound, high_bound, input ready);
    modport sink   (input valid, action, seed_value, low_bound, high_bound, output ready);
endinterface

interface xsr_res_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] int_value;
    logic [63:0]        real_bits;

    modport source (output valid, result_kind, int_value, real_bits, input ready);
    modport sink   (input valid, result_kind, int_value, real_bits, output ready);
endinterface

// ===== rtl/xsr_datapath.sv =====
// Datapath: generator state, seed mixer, shared 32x32 multiplier, remainder and normaliser.
module xsr_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  xsr_pkg::cmd_t      cmd,
    input  logic [63:0]        seed_value,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    output xsr_pkg::status_t   status,
    output logic               result_kind,
    output logic signed [31:0] int_value,
    output logic [63:0]        real_bits
);

    logic [63:0] gw_reg [4];
    logic [63:0] acc_reg;
    logic [63:0] z_reg;
    logic [63:0] prod_reg;
    logic [63:0] pp_reg;
    logic [63:0] rnd_reg;
    logic [31:0] rem_reg;
    logic [10:0] exp_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;
    logic [31:0] span_reg;
    logic        res_kind_reg;
    logic [31:0] res_int_reg;
    logic [63:0] res_real_reg;

    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] pp_next;
    logic [63:0] acc_sum;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] rot_out;
    logic [32:0] trial;
    logic [32:0] trial_diff;
    logic [31:0] offset;

    // shared multiplier: low 64 bits of z * constant from three partial products
    assign mul_const = cmd.mul_sel ? xsr_pkg::SM_MUL2 : xsr_pkg::SM_MUL1;
    assign mul_a     = (cmd.op == xsr_pkg::OP_MUL2) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (cmd.op == xsr_pkg::OP_MUL1) ? mul_const[63:32] : mul_const[31:0];
    assign pp_next   = mul_a * mul_b;

    assign acc_sum = acc_reg + xsr_pkg::SM_GAMMA;

    assign t2      = gw_reg[2] ^ gw_reg[0];
    assign t3      = gw_reg[3] ^ gw_reg[1];
    assign rot_out = {rnd_reg[63-xsr_pkg::ROT_OUT:0], rnd_reg[63:64-xsr_pkg::ROT_OUT]};

    assign trial      = {rem_reg, rnd_reg[63]};
    assign trial_diff = trial - {1'b0, span_reg};

    assign offset = status.full_span ? rnd_reg[31:0] : rem_reg;

    assign status.empty     = $signed(lo_reg) >= $signed(hi_reg);
    assign status.full_span = (span_reg == 32'd0);
    assign status.mant_top  = rnd_reg[52];
    assign status.mant_zero = (rnd_reg[52:0] == 53'd0);

    assign result_kind = res_kind_reg;
    assign int_value   = res_int_reg;
    assign real_bits   = res_real_reg;

    // generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg[0] <= xsr_pkg::GW_INIT0;
            gw_reg[1] <= xsr_pkg::GW_INIT1;
            gw_reg[2] <= xsr_pkg::GW_INIT2;
            gw_reg[3] <= xsr_pkg::GW_INIT3;
        end
        else if (cmd.op == xsr_pkg::OP_SM_STORE)
        begin
            gw_reg[cmd.word_idx] <= z_reg ^ (z_reg >> 31);
        end
        else if (cmd.op == xsr_pkg::OP_ADVANCE)
        begin
            gw_reg[0] <= gw_reg[0] ^ t3;
            gw_reg[1] <= gw_reg[1] ^ t2;
            gw_reg[2] <= t2 ^ (gw_reg[1] << xsr_pkg::SHIFT_W1);
            gw_reg[3] <= {t3[63-xsr_pkg::ROT_W3:0], t3[63:64-xsr_pkg::ROT_W3]};
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            xsr_pkg::OP_LOAD:
            begin
                acc_reg  <= seed_value;
                lo_reg   <= low_bound;
                hi_reg   <= high_bound;
                span_reg <= high_bound - low_bound + 32'd1;
            end
            xsr_pkg::OP_SM_ADD:
            begin
                acc_reg <= acc_sum;
                z_reg   <= acc_sum;
            end
            xsr_pkg::OP_SM_XS30:
            begin
                z_reg <= z_reg ^ (z_reg >> 30);
            end
            xsr_pkg::OP_SM_XS27:
            begin
                z_reg <= z_reg ^ (z_reg >> 27);
            end
            xsr_pkg::OP_MUL0:
            begin
                pp_reg <= pp_next;
            end
            xsr_pkg::OP_MUL1:
            begin
                prod_reg <= pp_reg;
                pp_reg   <= pp_next;
            end
            xsr_pkg::OP_MUL2:
            begin
                prod_reg <= prod_reg + {pp_reg[31:0], 32'd0};
                pp_reg   <= pp_next;
            end
            xsr_pkg::OP_MUL3:
            begin
                z_reg <= prod_reg + {pp_reg[31:0], 32'd0};
            end
            xsr_pkg::OP_ADVANCE:
            begin
                rnd_reg <= gw_reg[1] + (gw_reg[1] << 2);   // times 5
            end
            xsr_pkg::OP_SCRAMBLE:
            begin
                rnd_reg <= rot_out + (rot_out << 3);       // times 9
                rem_reg <= 32'd0;
            end
            xsr_pkg::OP_DIV_STEP:
            begin
                // restoring remainder, one dividend bit per step
                rem_reg <= trial_diff[32] ? trial[31:0] : trial_diff[31:0];
                rnd_reg <= rnd_reg << 1;
            end
            xsr_pkg::OP_REAL_INIT:
            begin
                rnd_reg <= rnd_reg >> 11;
                exp_reg <= xsr_pkg::EXP_START;
            end
            xsr_pkg::OP_NORM_STEP:
            begin
                rnd_reg <= rnd_reg << 1;
                exp_reg <= exp_reg - 11'd1;
            end
            xsr_pkg::OP_FIN_EMPTY:
            begin
                res_kind_reg <= 1'b0;
                res_int_reg  <= lo_reg;
                res_real_reg <= 64'd0;
            end
            xsr_pkg::OP_FIN_INT:
            begin
                res_kind_reg <= 1'b0;
                res_int_reg  <= lo_reg + offset;
                res_real_reg <= 64'd0;
            end
            xsr_pkg::OP_FIN_REAL:
            begin
                res_kind_reg <= 1'b1;
                res_int_reg  <= 32'd0;
                res_real_reg <= status.mant_zero ? 64'd0
                                                 : {1'b0, exp_reg, rnd_reg[51:0]};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/xsr_ctrl.sv =====
// Controller: sequences seeding, draws, remainder and normalisation; owns the handshakes.
module xsr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_action,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  xsr_pkg::status_t status,
    output xsr_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SM_ADD,
        S_SM_XS30,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SM_XS27,
        S_SM_STORE,
        S_INT_SEL,
        S_ADVANCE,
        S_SCRAMBLE,
        S_DIV,
        S_REAL_INIT,
        S_NORM,
        S_FIN_EMPTY,
        S_FIN_INT,
        S_FIN_REAL
    } state_t;

    state_t                     state_reg;
    logic                       mul_sel_reg;
    logic [1:0]                 word_reg;
    logic                       real_reg;
    logic [xsr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                       out_valid_reg;

    logic slot_free;
    logic norm_done;
    logic load_result;

    assign slot_free   = !out_valid_reg || out_ready;
    assign norm_done   = status.mant_top || status.mant_zero;
    assign load_result = slot_free && (state_reg == S_FIN_EMPTY || state_reg == S_FIN_INT
                                       || state_reg == S_FIN_REAL);
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        cmd.mul_sel  = mul_sel_reg;
        cmd.word_idx = word_reg;
        unique case (state_reg)
            S_IDLE:      cmd.op = in_valid ? xsr_pkg::OP_LOAD : xsr_pkg::OP_NONE;
            S_SM_ADD:    cmd.op = xsr_pkg::OP_SM_ADD;
            S_SM_XS30:   cmd.op = xsr_pkg::OP_SM_XS30;
            S_MUL0:      cmd.op = xsr_pkg::OP_MUL0;
            S_MUL1:      cmd.op = xsr_pkg::OP_MUL1;
            S_MUL2:      cmd.op = xsr_pkg::OP_MUL2;
            S_MUL3:      cmd.op = xsr_pkg::OP_MUL3;
            S_SM_XS27:   cmd.op = xsr_pkg::OP_SM_XS27;
            S_SM_STORE:  cmd.op = xsr_pkg::OP_SM_STORE;
            S_INT_SEL:   cmd.op = xsr_pkg::OP_NONE;
            S_ADVANCE:   cmd.op = xsr_pkg::OP_ADVANCE;
            S_SCRAMBLE:  cmd.op = xsr_pkg::OP_SCRAMBLE;
            S_DIV:       cmd.op = xsr_pkg::OP_DIV_STEP;
            S_REAL_INIT: cmd.op = xsr_pkg::OP_REAL_INIT;
            S_NORM:      cmd.op = norm_done ? xsr_pkg::OP_NONE : xsr_pkg::OP_NORM_STEP;
            S_FIN_EMPTY: cmd.op = slot_free ? xsr_pkg::OP_FIN_EMPTY : xsr_pkg::OP_NONE;
            S_FIN_INT:   cmd.op = slot_free ? xsr_pkg::OP_FIN_INT : xsr_pkg::OP_NONE;
            S_FIN_REAL:  cmd.op = slot_free ? xsr_pkg::OP_FIN_REAL : xsr_pkg::OP_NONE;
            default:     cmd.op = xsr_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_sel_reg   <= 1'b0;
            word_reg      <= 2'd0;
            real_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mul_sel_reg <= 1'b0;
                        word_reg    <= 2'd0;
                        unique case (xsr_pkg::action_t'(in_action))
                            xsr_pkg::ACT_SEED:
                            begin
                                state_reg <= S_SM_ADD;
                            end
                            xsr_pkg::ACT_INT:
                            begin
                                real_reg  <= 1'b0;
                                state_reg <= S_INT_SEL;
                            end
                            xsr_pkg::ACT_REAL:
                            begin
                                real_reg  <= 1'b1;
                                state_reg <= S_ADVANCE;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SM_ADD:   state_reg <= S_SM_XS30;
                S_SM_XS30:  state_reg <= S_MUL0;
                S_MUL0:     state_reg <= S_MUL1;
                S_MUL1:     state_reg <= S_MUL2;
                S_MUL2:     state_reg <= S_MUL3;
                S_MUL3:     state_reg <= mul_sel_reg ? S_SM_STORE : S_SM_XS27;
                S_SM_XS27:
                begin
                    mul_sel_reg <= 1'b1;
                    state_reg   <= S_MUL0;
                end
                S_SM_STORE:
                begin
                    mul_sel_reg <= 1'b0;
                    word_reg    <= word_reg + 2'd1;
                    state_reg   <= (word_reg == 2'd3) ? S_IDLE : S_SM_ADD;
                end
                S_INT_SEL:  state_reg <= status.empty ? S_FIN_EMPTY : S_ADVANCE;
                S_ADVANCE:  state_reg <= S_SCRAMBLE;
                S_SCRAMBLE:
                begin
                    cnt_reg <= '0;
                    priority if (real_reg)
                        state_reg <= S_REAL_INIT;
                    else if (status.full_span)
                        state_reg <= S_FIN_INT;
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == xsr_pkg::DIV_CNT_W'(xsr_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_FIN_INT;
                    end
                end
                S_REAL_INIT: state_reg <= S_NORM;
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        state_reg <= S_FIN_REAL;
                    end
                end
                S_FIN_EMPTY, S_FIN_INT, S_FIN_REAL:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/xoshiro256ss_random_source.sv =====
// Top level: xoshiro256** random source with SplitMix64 seeding.
// One item at a time; request ready only while the controller is idle. A reseed
// mixes four words in turn. An integer draw runs the 64-step serial remainder, but
// skips the draw for empty or reversed bounds and the remainder for the full span.
// A real draw is set by the one-bit normaliser.
// Results wait in the output register; asynchronous reset loads the fixed words.
module xoshiro256ss_random_source
(
    input logic      clk,
    input logic      rst_n,
    xsr_req_if.sink   request,
    xsr_res_if.source result
);

    xsr_pkg::cmd_t    cmd;
    xsr_pkg::status_t status;

    xsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_action (request.action),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    xsr_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seed_value  (request.seed_value),
        .low_bound   (request.low_bound),
        .high_bound  (request.high_bound),
        .status      (status),
        .result_kind (result.result_kind),
        .int_value   (result.int_value),
        .real_bits   (result.real_bits)
    );

    // an unused action code leaves the block idle
    a_unused_action_idle: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready && request.action == xsr_pkg::ACT_NONE
        |=> cmd.op == xsr_pkg::OP_NONE || cmd.op == xsr_pkg::OP_LOAD)
        else $error("unused action started work");

    // full span takes the low output bits directly, never the remainder loop
    a_no_div_full_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == xsr_pkg::OP_DIV_STEP |-> !status.full_span)
        else $error("remainder step on full span");

    // normaliser never shifts past the leading one or a zero mantissa
    a_norm_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == xsr_pkg::OP_NORM_STEP |-> !status.mant_top && !status.mant_zero)
        else $error("normalise step after leading one found");

    // a result is only loaded when the output register is free
    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == xsr_pkg::OP_FIN_EMPTY || cmd.op == xsr_pkg::OP_FIN_INT
        || cmd.op == xsr_pkg::OP_FIN_REAL
        |-> !result.valid || result.ready)
        else $error("result overwritten before taken");

endmodule

// ===== dv/xoshiro256ss_random_source_test.sv =====
// Self-checking testbench of the xoshiro256** random source with SplitMix64 seeding.
`timescale 1ns / 100ps

module xoshiro256ss_random_source_test;

    localparam logic [63:0] XS_START0   = 64'h853c49e6748fea9b;
    localparam logic [63:0] XS_START1   = 64'hda3e39cb94b95bdb;
    localparam logic [63:0] XS_START2   = 64'h5b5ad4ceb667f385;
    localparam logic [63:0] XS_START3   = 64'h9266677dc26f26e8;
    localparam logic [63:0] SPLIT_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SPLIT_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SPLIT_MUL_B = 64'h94d049bb133111eb;

    // seed + 2*gamma wraps to zero, so the second word is zero and the first draw is zero
    localparam logic [63:0] ZERO_DRAW_SEED = 64'd0 - {SPLIT_GAMMA[62:0], 1'b0};

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 420;
    localparam int PRINT_CAP    = 100;

    typedef struct {
        xsr_pkg::action_t   action;
        logic [63:0]        seed;
        logic signed [31:0] lo_bound;
        logic signed [31:0] hi_bound;
    } rng_request_t;

    typedef struct {
        logic        kind;
        logic [31:0] int_value;
        logic [63:0] real_bits;
    } draw_result_t;

    logic clk;
    logic rst_n;
    logic hold_off;
    logic hold_go;

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int cycle_count;

    logic [63:0]  gen_word [4];
    rng_request_t queued_requests [$];
    draw_result_t expected_draws [$];

    xsr_req_if request_ch ();
    xsr_res_if result_ch ();

    xoshiro256ss_random_source uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        // keep the log readable when the design is badly broken
        if (error_count < PRINT_CAP)
            $display("%0t: mismatch: %s", $time, what);
        error_count++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] splitmix_next(inout logic [63:0] acc);
        logic [63:0] z;
        acc = acc + SPLIT_GAMMA;
        z = acc;
        z = (z ^ (z >> 30)) * SPLIT_MUL_A;
        z = (z ^ (z >> 27)) * SPLIT_MUL_B;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] gen_advance();
        logic [63:0] prod;
        logic [63:0] draw;
        logic [63:0] shl;
        prod = gen_word[1] * 64'd5;
        draw = {prod[56:0], prod[63:57]} * 64'd9;
        shl = gen_word[1] << 17;
        gen_word[2] ^= gen_word[0];
        gen_word[3] ^= gen_word[1];
        gen_word[1] ^= gen_word[2];
        gen_word[0] ^= gen_word[3];
        gen_word[2] ^= shl;
        gen_word[3] = {gen_word[3][18:0], gen_word[3][63:19]};
        return draw;
    endfunction

    // double of m * 2^-53; exact since m has at most 53 bits
    function automatic logic [63:0] unit_double_bits(input logic [52:0] m);
        int msb;
        logic [63:0] frac;
        msb = -1;
        for (int i = 0; i < 53; i++)
            if (m[i])
                msb = i;
        if (msb < 0)
            return 64'd0;
        frac = {11'd0, m} << (52 - msb);
        return {1'b0, 11'(970 + msb), frac[51:0]};
    endfunction

    task automatic predict_request(input rng_request_t rq);
        logic [63:0]  acc;
        logic [63:0]  draw;
        logic [31:0]  span;
        logic [31:0]  offset;
        draw_result_t res;
        case (rq.action)
            xsr_pkg::ACT_SEED:
            begin
                acc = rq.seed;
                for (int w = 0; w < 4; w++)
                    gen_word[w] = splitmix_next(acc);
            end
            xsr_pkg::ACT_INT:
            begin
                res.kind = 1'b0;
                res.real_bits = 64'd0;
                if (rq.lo_bound >= rq.hi_bound)
                begin
                    res.int_value = rq.lo_bound;
                end
                else
                begin
                    draw = gen_advance();
                    span = rq.hi_bound - rq.lo_bound + 32'd1;
                    // span wraps to zero only for the full 32-bit range
                    offset = (span == 32'd0) ? draw[31:0] : 32'(draw % {32'd0, span});
                    res.int_value = rq.lo_bound + offset;
                end
                expected_draws.push_back(res);
            end
            xsr_pkg::ACT_REAL:
            begin
                draw = gen_advance();
                res.kind = 1'b1;
                res.int_value = 32'd0;
                res.real_bits = unit_double_bits(draw[63:11]);
                expected_draws.push_back(res);
            end
            default:
            begin
                // unused code: ignored by the block
            end
        endcase
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin : request_driver
        logic taken;
        if (!rst_n)
        begin
            request_ch.valid      <= 1'b0;
            request_ch.action     <= xsr_pkg::ACT_SEED;
            request_ch.seed_value <= 64'd0;
            request_ch.low_bound  <= 32'd0;
            request_ch.high_bound <= 32'd0;
            gen_word[0] = XS_START0;
            gen_word[1] = XS_START1;
            gen_word[2] = XS_START2;
            gen_word[3] = XS_START3;
        end
        else
        begin
            taken = request_ch.valid && request_ch.ready;
            if (taken)
                predict_request(queued_requests.pop_front());
            if (taken || !request_ch.valid)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    request_ch.valid      <= 1'b1;
                    request_ch.action     <= queued_requests[0].action;
                    request_ch.seed_value <= queued_requests[0].seed;
                    request_ch.low_bound  <= queued_requests[0].lo_bound;
                    request_ch.high_bound <= queued_requests[0].hi_bound;
                end
                else
                begin
                    request_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : result_monitor
        draw_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_draws.size() == 0)
                begin
                    report_mismatch("result item with nothing expected");
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (result_ch.result_kind !== want.kind)
                        report_mismatch($sformatf("result_kind %b, expected %b",
                                                  result_ch.result_kind, want.kind));
                    if (result_ch.int_value !== want.int_value)
                        report_mismatch($sformatf("int_value %h, expected %h",
                                                  result_ch.int_value, want.int_value));
                    if (result_ch.real_bits !== want.real_bits)
                        report_mismatch($sformatf("real_bits %h, expected %h",
                                                  result_ch.real_bits, want.real_bits));
                end
            end
            result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial
    begin : receiver_hold
        hold_off = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[xoshiro256ss_random_source] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_request(input xsr_pkg::action_t a, input logic [63:0] seed,
                               input logic [31:0] lo, input logic [31:0] hi);
        rng_request_t rq;
        rq.action = a;
        rq.seed = seed;
        rq.lo_bound = lo;
        rq.hi_bound = hi;
        queued_requests.push_back(rq);
    endtask

    task automatic wait_drained();
        while (queued_requests.size() != 0 || request_ch.valid || expected_draws.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_requests(input int count);
        int          pick;
        int          added;
        logic [63:0] seed;
        logic [31:0] lo;
        logic [31:0] hi;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            seed = {$urandom, $urandom};
            lo = $urandom;
            hi = $urandom;
            if (pick < 8)
            begin
                add_request(xsr_pkg::ACT_SEED, seed, lo, hi);
                added++;
            end
            else if (pick < 55)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: hi = lo + $urandom_range(1000);
                    4, 5: ;
                    6:
                    begin
                        lo = INT_MIN;
                        hi = INT_MAX;
                    end
                    7: hi = lo + ((32'd1 << $urandom_range(31)) - 32'd1);
                    8:
                    begin
                        lo = INT_MIN + $urandom_range(3);
                        hi = INT_MAX - $urandom_range(3);
                    end
                    default: hi = lo - $urandom_range(1);
                endcase
                add_request(xsr_pkg::ACT_INT, seed, lo, hi);
                added++;
            end
            else if (pick < 96)
            begin
                add_request(xsr_pkg::ACT_REAL, seed, lo, hi);
                added++;
            end
            else
            begin
                add_request(xsr_pkg::ACT_NONE, seed, lo, hi);
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        hold_go = 1'b0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        request_ch.valid = 1'b0;
        request_ch.action = xsr_pkg::ACT_SEED;
        request_ch.seed_value = 64'd0;
        request_ch.low_bound = 32'd0;
        request_ch.high_bound = 32'd0;
        result_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset state first, then bound extremes, seeds and the zero draw
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, 32'd0, 32'd9);
        add_request(xsr_pkg::ACT_REAL, {$urandom, $urandom}, $urandom, $urandom);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, INT_MIN, INT_MAX);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, 32'd5, 32'd5);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, INT_MAX, INT_MIN);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, INT_MIN, INT_MIN + 32'd1);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, INT_MAX - 32'd1, INT_MAX);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, 32'hffff_ffff, 32'd0);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, INT_MIN, INT_MAX - 32'd1);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, INT_MIN + 32'd1, INT_MAX);
        add_request(xsr_pkg::ACT_NONE, {64{1'b1}}, 32'hffff_ffff, 32'hffff_ffff);
        add_request(xsr_pkg::ACT_SEED, 64'd0, $urandom, $urandom);
        add_request(xsr_pkg::ACT_REAL, {$urandom, $urandom}, $urandom, $urandom);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, 32'd0, 32'd1);
        add_request(xsr_pkg::ACT_SEED, {64{1'b1}}, $urandom, $urandom);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, -32'sd1000, 32'sd1000);
        add_request(xsr_pkg::ACT_REAL, {$urandom, $urandom}, $urandom, $urandom);
        add_request(xsr_pkg::ACT_SEED, ZERO_DRAW_SEED, $urandom, $urandom);
        add_request(xsr_pkg::ACT_REAL, {$urandom, $urandom}, $urandom, $urandom);
        add_request(xsr_pkg::ACT_SEED, ZERO_DRAW_SEED, $urandom, $urandom);
        add_request(xsr_pkg::ACT_INT, {$urandom, $urandom}, INT_MIN, INT_MAX);
        add_request(xsr_pkg::ACT_NONE, 64'd0, 32'd0, 32'd0);
        add_request(xsr_pkg::ACT_REAL, {$urandom, $urandom}, $urandom, $urandom);
        wait_drained();

        // no idling, with the long receiver hold-off at the start
        hold_go = 1'b1;
        random_requests(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 55;
        random_requests(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 55;
        random_requests(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 11;
        recv_stall_pct = 11;
        random_requests(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_draws.size() == 0)
            $display("[xoshiro256ss_random_source] OK");
        else
            $display("[xoshiro256ss_random_source] ERROR");
        $finish;
    end

endmodule
